// ----- rtl/core/eaq_pkg.sv -----
package eaq_pkg;

    localparam int DATA_W = 32;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = 31;
    localparam int PROD_W = 2 * DATA_W;

    // One in the units of the squared half-angle sum (2^-58).
    localparam logic [RAD_W-1:0] ONE_S   = 64'd1 << 58;
    // Numerator of the reciprocal root: 2^59.
    localparam logic [RAD_W-1:0] DIV_NUM = 64'd1 << 59;
    // One in Q2.30.
    localparam logic [DATA_W-1:0] ONE_Q  = 32'd1 << 30;
    // Lower bound on the square root that the large-angle branch can see.
    localparam logic [ROOT_W-1:0] ROOT_MIN = 32'd1 << 29;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } quat_t;

    // Payload that rides alongside the root and divider stages.
    typedef struct packed {
        vec_t  d;
        quat_t q;
        logic  big_angle;
    } side_t;

endpackage

// ----- rtl/core/eaq_sqrt.sv -----
module eaq_sqrt
    import eaq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             out_side
);

    logic              valid_reg [ROOT_W];
    logic [RAD_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];

    // Each stage settles one bit of the root, most significant first.
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        localparam int B = ROOT_W - 1 - k;

        logic              v_in;
        logic [RAD_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        side_t             side_in;
        logic [RAD_W+1:0]  trial;
        logic              fits;
        logic              valid_next;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_in} << (B + 1))
                  + ({{(RAD_W+1){1'b0}}, 1'b1} << (2 * B));
            fits       = {2'b00, rem_in} >= trial;
            valid_next = v_in;
            rem_next   = fits ? (rem_in - trial[RAD_W-1:0]) : rem_in;
            root_next  = fits ? (root_in | ({{(ROOT_W-1){1'b0}}, 1'b1} << B)) : root_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ----- rtl/core/eaq_div.sv -----
module eaq_div
    import eaq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [ROOT_W-1:0] divisor_out,
    output side_t             out_side
);

    logic              valid_reg [QUO_W];
    logic [RAD_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [ROOT_W-1:0] dvs_reg   [QUO_W];
    side_t             side_reg  [QUO_W];

    // Restoring division of 2^59 by the root, one quotient bit a stage.
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int B = QUO_W - 1 - k;

        logic              v_in;
        logic [RAD_W-1:0]  rem_in;
        logic [QUO_W-1:0]  quo_in;
        logic [ROOT_W-1:0] dvs_in;
        side_t             side_in;
        logic [RAD_W-1:0]  trial;
        logic              fits;
        logic              valid_next;
        logic [RAD_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = DIV_NUM;
            assign quo_in  = '0;
            assign dvs_in  = divisor;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial      = {{(RAD_W-ROOT_W){1'b0}}, dvs_in} << B;
            fits       = rem_in >= trial;
            valid_next = v_in;
            rem_next   = fits ? (rem_in - trial) : rem_in;
            quo_next   = fits ? (quo_in | ({{(QUO_W-1){1'b0}}, 1'b1} << B)) : quo_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_next;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            quo_reg[k]  <= quo_next;
            dvs_reg[k]  <= dvs_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid   = valid_reg[QUO_W-1];
    assign quotient    = quo_reg[QUO_W-1];
    assign divisor_out = dvs_reg[QUO_W-1];
    assign out_side    = side_reg[QUO_W-1];

endmodule

// ----- rtl/core/eaq_hprod.sv -----
module eaq_hprod
    import eaq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  quat_t e,
    input  quat_t q,
    output logic  out_valid,
    output quat_t result
);

    logic signed [PROD_W-1:0] p_next [16];
    logic signed [PROD_W-1:0] p_reg  [16];
    logic signed [PROD_W:0]   pair_next [8];
    logic signed [PROD_W:0]   pair_reg  [8];
    logic signed [PROD_W+1:0] acc       [4];
    logic signed [PROD_W+1:0] acc_sh    [4];
    logic [DATA_W-1:0]        sat       [4];
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    quat_t                    result_next;
    quat_t                    result_reg;

    // Product index is 4 * (error component) + (prior component), w x y z.
    always_comb
    begin
        p_next[0]  = e.w * q.w;
        p_next[1]  = e.w * q.x;
        p_next[2]  = e.w * q.y;
        p_next[3]  = e.w * q.z;
        p_next[4]  = e.x * q.w;
        p_next[5]  = e.x * q.x;
        p_next[6]  = e.x * q.y;
        p_next[7]  = e.x * q.z;
        p_next[8]  = e.y * q.w;
        p_next[9]  = e.y * q.x;
        p_next[10] = e.y * q.y;
        p_next[11] = e.y * q.z;
        p_next[12] = e.z * q.w;
        p_next[13] = e.z * q.x;
        p_next[14] = e.z * q.y;
        p_next[15] = e.z * q.z;
    end

    always_comb
    begin
        pair_next[0] = p_reg[0] - p_reg[5];
        pair_next[1] = -p_reg[10] - p_reg[15];
        pair_next[2] = p_reg[1] + p_reg[4];
        pair_next[3] = p_reg[11] - p_reg[14];
        pair_next[4] = p_reg[2] + p_reg[8];
        pair_next[5] = p_reg[13] - p_reg[7];
        pair_next[6] = p_reg[3] + p_reg[12];
        pair_next[7] = p_reg[6] - p_reg[9];
    end

    // Floor to Q2.30, then clamp wherever the upper bits disagree with the sign.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i]    = pair_reg[2*i] + pair_reg[2*i+1];
            acc_sh[i] = acc[i] >>> 30;
            if (acc_sh[i][PROD_W+1:DATA_W-1] == '0
                || acc_sh[i][PROD_W+1:DATA_W-1] == '1)
            begin
                sat[i] = acc_sh[i][DATA_W-1:0];
            end
            else
            begin
                sat[i] = acc_sh[i][PROD_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
        result_next.w = sat[0];
        result_next.x = sat[1];
        result_next.y = sat[2];
        result_next.z = sat[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        pair_reg   <= pair_next;
        result_reg <= result_next;
    end

    assign out_valid = v3_reg;
    assign result    = result_reg;

endmodule

// ----- rtl/core/error_angle_quaternion_update.sv -----
// Multiplicative attitude-error quaternion update. Each item (error angle in
// Q4.28, prior quaternion in Q2.30) is taken whenever start is high; busy is
// always low, so a new item may enter in every clock cycle. Its result is on
// out_w..out_z, with done high, for the one cycle that ends at the 71st rising
// edge after the accepting edge, and must be captured at that edge. The pipeline
// is a 32-stage square root and a 31-stage reciprocal divider, each settling
// one bit per stage, plus eight stages of squaring, multiplying and summing.
module error_angle_quaternion_update
    import eaq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] delta_x,
    input  logic signed [DATA_W-1:0] delta_y,
    input  logic signed [DATA_W-1:0] delta_z,
    input  logic signed [DATA_W-1:0] quat_w,
    input  logic signed [DATA_W-1:0] quat_x,
    input  logic signed [DATA_W-1:0] quat_y,
    input  logic signed [DATA_W-1:0] quat_z,
    output logic                     done,
    output logic signed [DATA_W-1:0] out_w,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_z
);

    localparam int LATENCY = 3 + ROOT_W + QUO_W + 5;

    logic              in_valid_reg;
    side_t             in_side_reg;
    side_t             in_side_next;

    logic              sq_valid_reg;
    logic [RAD_W-1:0]  sq_reg [3];
    logic [RAD_W-1:0]  sq_next [3];
    logic [DATA_W-1:0] mag [3];
    side_t             sq_side_reg;

    logic              rad_valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [RAD_W-1:0]  sum_sq;
    side_t             rad_side_reg;
    side_t             rad_side_next;

    logic              sqrt_valid;
    logic [ROOT_W-1:0] sqrt_root;
    side_t             sqrt_side;

    logic              div_valid;
    logic [QUO_W-1:0]  div_quo;
    logic [ROOT_W-1:0] div_root;
    side_t             div_side;

    logic                     e1_valid_reg;
    logic signed [DATA_W-1:0] ew_reg;
    logic signed [DATA_W-1:0] ew_next;
    logic signed [PROD_W-1:0] pv_reg  [3];
    logic signed [PROD_W-1:0] pv_next [3];
    side_t                    e1_side_reg;

    logic        e2_valid_reg;
    quat_t       e_reg;
    quat_t       e_next;
    quat_t       q_reg;
    logic signed [PROD_W-1:0] pv_sh [3];

    logic        hp_valid;
    quat_t       hp_result;

    assign busy = 1'b0;

    always_comb
    begin
        in_side_next.d.x  = delta_x;
        in_side_next.d.y  = delta_y;
        in_side_next.d.z  = delta_z;
        in_side_next.q.w  = quat_w;
        in_side_next.q.x  = quat_x;
        in_side_next.q.y  = quat_y;
        in_side_next.q.z  = quat_z;
        in_side_next.big_angle = 1'b0;
    end

    // Squares of the angle magnitudes; the magnitude of the most negative
    // value still fits as an unsigned word.
    always_comb
    begin
        mag[0] = in_side_reg.d.x[DATA_W-1] ? (~in_side_reg.d.x + 1'b1) : in_side_reg.d.x;
        mag[1] = in_side_reg.d.y[DATA_W-1] ? (~in_side_reg.d.y + 1'b1) : in_side_reg.d.y;
        mag[2] = in_side_reg.d.z[DATA_W-1] ? (~in_side_reg.d.z + 1'b1) : in_side_reg.d.z;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = mag[i] * mag[i];
        end
    end

    // The sum of three squares stays at or below 3 * 2^62, so it never wraps.
    always_comb
    begin
        sum_sq        = sq_reg[0] + sq_reg[1] + sq_reg[2];
        rad_side_next = sq_side_reg;
        rad_side_next.big_angle = sum_sq > ONE_S;
        if (sum_sq > ONE_S)
        begin
            rad_next = ONE_S + sum_sq;
        end
        else
        begin
            rad_next = (ONE_S - sum_sq) << 2;
        end
    end

    always_comb
    begin
        if (div_side.big_angle)
        begin
            ew_next = $signed({1'b0, div_quo});
        end
        else
        begin
            ew_next = $signed(div_root);
        end
        pv_next[0] = $signed({1'b0, div_quo}) * div_side.d.x;
        pv_next[1] = $signed({1'b0, div_quo}) * div_side.d.y;
        pv_next[2] = $signed({1'b0, div_quo}) * div_side.d.z;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pv_sh[i] = pv_reg[i] >>> 29;
        end
        e_next.w = ew_reg;
        if (e1_side_reg.big_angle)
        begin
            e_next.x = pv_sh[0][DATA_W-1:0];
            e_next.y = pv_sh[1][DATA_W-1:0];
            e_next.z = pv_sh[2][DATA_W-1:0];
        end
        else
        begin
            e_next.x = {e1_side_reg.d.x[DATA_W-2:0], 1'b0};
            e_next.y = {e1_side_reg.d.y[DATA_W-2:0], 1'b0};
            e_next.z = {e1_side_reg.d.z[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            rad_valid_reg <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            sq_valid_reg  <= in_valid_reg;
            rad_valid_reg <= sq_valid_reg;
            e1_valid_reg  <= div_valid;
            e2_valid_reg  <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_side_reg  <= in_side_next;
        sq_reg       <= sq_next;
        sq_side_reg  <= in_side_reg;
        rad_reg      <= rad_next;
        rad_side_reg <= rad_side_next;
        ew_reg       <= ew_next;
        pv_reg       <= pv_next;
        e1_side_reg  <= div_side;
        e_reg        <= e_next;
        q_reg        <= e1_side_reg.q;
    end

    eaq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_valid_reg),
        .radicand  (rad_reg),
        .in_side   (rad_side_reg),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    eaq_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sqrt_valid),
        .divisor     (sqrt_root),
        .in_side     (sqrt_side),
        .out_valid   (div_valid),
        .quotient    (div_quo),
        .divisor_out (div_root),
        .out_side    (div_side)
    );

    eaq_hprod u_hprod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e2_valid_reg),
        .e         (e_reg),
        .q         (q_reg),
        .out_valid (hp_valid),
        .result    (hp_result)
    );

    assign done  = hp_valid;
    assign out_w = hp_result.w;
    assign out_x = hp_result.x;
    assign out_y = hp_result.y;
    assign out_z = hp_result.z;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without an item accepted at the pipeline latency");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (sqrt_valid && sqrt_side.big_angle) |-> (sqrt_root >= ROOT_MIN))
        else $error("large-angle root below one");

    a_ew_range: assert property (@(posedge clk) disable iff (!rst_n)
        e2_valid_reg |-> (!e_reg.w[DATA_W-1] && e_reg.w <= $signed(ONE_Q)))
        else $error("error quaternion scalar part outside zero to one");
`endif

endmodule
